// File: src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define RWE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define RWE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/rwe_pkg.sv
// Package: widths, step counts and the state type of the moving RMS envelope.
package rwe_pkg;

  localparam int unsigned SAMPLE_W = 16;  // input sample width
  localparam int unsigned SQ_W     = 31;  // square of a magnitude up to 2^15
  localparam int unsigned SUM_W    = 36;  // running window sum, wraps
  localparam int unsigned CNT_W    = 7;   // saturating sample counter
  localparam int unsigned HALF_W   = 5;   // half window register
  localparam int unsigned RING_AW  = 6;   // history ring address
  localparam int unsigned DIV_W    = 6;   // window count, 1..63
  localparam int unsigned ROOT_W   = SUM_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 4;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned STEP_W   = 5;

  localparam logic [HALF_W-1:0] HALF_RESET = 5'd2;

  // Start value of each serial unit's step counter, loaded as "steps - 1".
  localparam logic [STEP_W-1:0] SQR_LAST  = STEP_W'(SAMPLE_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W / 2 - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_UPD,
    ST_PREP,
    ST_DIV,
    ST_ROOT,
    ST_EMIT
  } state_e;

endpackage

// File: src/rms_window_envelope.sv
// Centered moving RMS envelope: serial square, running sum, serial divide and root.
// An accepted sample steps through square and update and, if it yields a result, through
// prepare, divide, root and emit; no new sample is taken until the block is back in idle.
// Each further flushed result repeats prepare, divide (radix-4) and root (2-bit) and emit.
// Reset (rst_ni low, asynchronous): window sum, counters and ring pointer go to zero,
// half_window goes to 2; the history ring is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module rms_window_envelope import rwe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [HALF_W-1:0]          half_window_i,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_sample_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [OUT_W-1:0]           rms_level_o,
  output logic                       last_result_o
);

  // Control state (reset)
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [HALF_W-1:0]   half_q, half_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    seen_q, seen_d;
  logic [RING_AW-1:0]  wp_q, wp_d;
  logic                out_valid_q, out_valid_d;

  // Payload (no reset)
  logic [SQ_W-1:0]     mcand_q, mcand_d;   // shifted multiplicand of the square
  logic [SAMPLE_W-1:0] mplier_q, mplier_d; // multiplier bits, consumed LSB first
  logic [SQ_W-1:0]     acc_q, acc_d;       // square accumulator
  logic                last_q, last_d;     // item carries the end-of-signal flag
  logic [CNT_W-1:0]    k_q, k_d;           // samples seen before this item
  logic [HALF_W-1:0]   d_q, d_d;           // distance of the pending result from the end
  logic [DIV_W-1:0]    cnt_q, cnt_d;       // window count, the divisor
  logic [SUM_W-1:0]    dq_q, dq_d;         // dividend in, quotient out, then root operand
  logic [DIV_W-1:0]    drem_q, drem_d;     // division remainder
  logic [REM_W-1:0]    rem_q, rem_d;       // root remainder
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [RING_AW-1:0]  rd_addr_q, rd_addr_d;
  logic [SQ_W-1:0]     rd_data_q;
  logic [OUT_W-1:0]    rms_q, rms_d;
  logic                last_res_q, last_res_d;

  // History ring of squares
  logic [SQ_W-1:0]     ring_mem [2**RING_AW];
  logic                ram_we;

  logic [SAMPLE_W-1:0] raw, mag;
  logic [CNT_W-1:0]    lim;       // d + h, the far edge of the pending window
  logic [CNT_W-1:0]    span;      // 2h + 1, the full window
  logic [CNT_W-1:0]    cnt_full;
  logic                emit_go;
  logic [DIV_W:0]      div_s1, div_s2;
  logic [REM_W-1:0]    rt_shift, rt_trial;

  // One restoring division step: returns {remainder, quotient bit}.
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
                                              input logic             b,
                                              input logic [DIV_W-1:0] dv);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    t    = {r, b};
    diff = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      return {diff[DIV_W-1:0], 1'b1};
    end
    return {t[DIV_W-1:0], 1'b0};
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign rms_level_o   = rms_q;
  assign last_result_o = last_res_q;

  assign raw      = sample_i;
  // Two's complement magnitude; the most negative sample maps to 2^15 unchanged.
  assign mag      = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
  assign lim      = {2'b00, d_q} + {2'b00, half_q};
  assign span     = {1'b0, half_q, 1'b1};
  assign cnt_full = ((k_q < lim) ? k_q : lim) + CNT_W'(1);
  assign emit_go  = !out_valid_q || out_ready_i;

  assign div_s1   = div_step(drem_q, dq_q[SUM_W-1], cnt_q);
  assign div_s2   = div_step(div_s1[DIV_W:1], dq_q[SUM_W-2], cnt_q);

  assign rt_shift = {rem_q[REM_W-3:0], dq_q[SUM_W-1:SUM_W-2]};
  assign rt_trial = {2'b00, root_q, 2'b01};

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    half_d      = half_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    wp_d        = wp_q;
    out_valid_d = out_valid_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    last_d      = last_q;
    k_d         = k_q;
    d_d         = d_q;
    cnt_d       = cnt_q;
    dq_d        = dq_q;
    drem_d      = drem_q;
    rem_d       = rem_q;
    root_d      = root_q;
    rd_addr_d   = rd_addr_q;
    rms_d       = rms_q;
    last_res_d  = last_res_q;
    ram_we      = 1'b0;

    if (cfg_valid_i) begin
      half_d = half_window_i;
    end
    // Drop the held result once the sink takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mcand_d   = SQ_W'(mag);
          mplier_d  = mag;
          acc_d     = '0;
          last_d    = last_sample_i;
          k_d       = seen_q;
          // Fetch the square that leaves a full window.
          rd_addr_d = wp_q - {half_q, 1'b1};
          step_d    = SQR_LAST;
          state_d   = ST_SQR;
        end
      end
      ST_SQR: begin
        // Shift-add square, one multiplier bit a cycle.
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[SQ_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[SAMPLE_W-1:1]};
        step_d   = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        ram_we = 1'b1;
        sum_d  = sum_q + SUM_W'(acc_q)
               - ((k_q >= span) ? SUM_W'(rd_data_q) : SUM_W'(0));
        if (last_q) begin
          d_d     = (k_q < {2'b00, half_q}) ? k_q[HALF_W-1:0] : half_q;
          state_d = ST_PREP;
        end else begin
          if (seen_q != CNT_SAT) begin
            seen_d = seen_q + CNT_W'(1);
          end
          wp_d = wp_q + RING_AW'(1);
          // With d = h the flush count formula gives min(k + 1, 2h + 1).
          d_d  = half_q;
          if (k_q >= {2'b00, half_q}) begin
            state_d = ST_PREP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PREP: begin
        cnt_d     = cnt_full[DIV_W-1:0];
        dq_d      = sum_q;
        drem_d    = '0;
        // Fetch the square that leaves the window once this result is out.
        rd_addr_d = wp_q - lim[RING_AW-1:0];
        step_d    = DIV_LAST;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        // Radix-4 restoring divide: two quotient bits a cycle.
        dq_d   = {dq_q[SUM_W-3:0], div_s1[0], div_s2[0]};
        drem_d = div_s2[DIV_W:1];
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = ROOT_LAST;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        // Digit-by-digit root: two operand bits in, one root bit out.
        dq_d = {dq_q[SUM_W-3:0], 2'b00};
        if (rt_shift >= rt_trial) begin
          rem_d  = rt_shift - rt_trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rt_shift;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold here until the output register is free.
        if (emit_go) begin
          out_valid_d = 1'b1;
          rms_d       = (root_q > ROOT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                          : root_q[OUT_W-1:0];
          last_res_d  = last_q && (d_q == '0);
          if (last_q && (d_q == '0)) begin
            sum_d   = '0;
            seen_d  = '0;
            wp_d    = '0;
            state_d = ST_IDLE;
          end else if (last_q) begin
            if (k_q >= lim) begin
              sum_d = sum_q - SUM_W'(rd_data_q);
            end
            d_d     = d_q - HALF_W'(1);
            state_d = ST_PREP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      half_q      <= HALF_RESET;
      sum_q       <= '0;
      seen_q      <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      half_q      <= half_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    acc_q      <= acc_d;
    last_q     <= last_d;
    k_q        <= k_d;
    d_q        <= d_d;
    cnt_q      <= cnt_d;
    dq_q       <= dq_d;
    drem_q     <= drem_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    rd_addr_q  <= rd_addr_d;
    rms_q      <= rms_d;
    last_res_q <= last_res_d;
  end

  // History ring: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ring_mem[wp_q] <= acc_q;
    end
    rd_data_q <= ring_mem[rd_addr_q];
  end

  `RWE_ASSERT_NEXT(a_accept_starts_square, in_valid_i && in_ready_o, state_q == ST_SQR)
  `RWE_ASSERT_NEXT(a_emit_waits_on_sink, state_q == ST_EMIT && !emit_go, state_q == ST_EMIT)
  `RWE_ASSERT_IMPL(a_distance_in_range, state_q == ST_PREP, d_q <= half_q)
  `RWE_ASSERT_NEXT(a_flush_clears, state_q == ST_EMIT && emit_go && last_q && d_q == '0, seen_q == '0 && wp_q == '0 && sum_q == '0)

endmodule

// File: verif/testbench.sv
// Testbench for the centered moving RMS envelope: directed and random sample streams.
module testbench;
  import rwe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct {
    logic [OUT_W-1:0] level;
    logic             last;
  } level_item_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [HALF_W-1:0]          half_window_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       last_sample_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [OUT_W-1:0]           rms_level_o;
  logic                       last_result_o;

  rms_window_envelope DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .half_window_i(half_window_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rms_level_o  (rms_level_o),
    .last_result_o(last_result_o)
  );

  // Stimulus bookkeeping: samples waiting for the driver, and counts of the
  // samples queued and taken by the block.
  sample_item_t sample_queue[$];
  sample_item_t next_sample;
  int unsigned  samples_queued;
  int unsigned  samples_taken;

  // Expected envelope values, oldest first.
  level_item_t  pending_levels[$];
  level_item_t  oldest_level;
  int unsigned  fail_count;
  int unsigned  cycle_count;

  // Idling controls, set per phase.
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;
  bit           hold_req;
  int unsigned  hold_left;

  // Predictor state: squares ring, running window sum, sample counter,
  // ring write position and the current half window.
  logic [SQ_W-1:0]    square_ring[64];
  logic [SUM_W-1:0]   window_total;
  logic [6:0]         seen_count;
  logic [RING_AW-1:0] ring_pos;
  logic [HALF_W-1:0]  half_cfg;

  // Clock: period of 2 time units.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Floor of the square root of a 36-bit value, one result bit per pass.
  function automatic logic [17:0] floor_root(logic [SUM_W-1:0] v);
    logic [17:0] r;
    logic [17:0] t;
    r = '0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (18'd1 << b);
      if (SUM_W'(t) * SUM_W'(t) <= v) r = t;
    end
    return r;
  endfunction

  // Square stored 'back' positions behind the write position, ring wraps.
  function automatic logic [SQ_W-1:0] square_back(int back);
    logic [RING_AW-1:0] idx;
    idx = ring_pos - RING_AW'(back);
    return square_ring[idx];
  endfunction

  // Queue one expected value: window mean, floored root, saturate to 16 bits.
  function automatic void expect_level(logic [SUM_W-1:0] sum, int count, logic last);
    logic [SUM_W-1:0] mean;
    logic [17:0]      root;
    level_item_t      lv;
    mean = sum / SUM_W'(count);
    root = floor_root(mean);
    lv.level = (root > 18'd65535) ? 16'hFFFF : root[15:0];
    lv.last = last;
    pending_levels.push_back(lv);
  endfunction

  // Advance the envelope state by one sample and queue the values it releases.
  function automatic void predict_envelope(logic signed [SAMPLE_W-1:0] s, logic last);
    logic [SAMPLE_W-1:0] mag;
    logic [SQ_W-1:0]     sq;
    int                  k;
    int                  h;
    int                  d;
    int                  lim;
    mag = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
    sq = SQ_W'(mag) * SQ_W'(mag);
    h = int'(half_cfg);
    k = int'(seen_count);
    square_ring[ring_pos] = sq;
    window_total = window_total + SUM_W'(sq);
    // Drop the square that just left a full window.
    if (k >= 2 * h + 1) window_total = window_total - SUM_W'(square_back(2 * h + 1));
    if (!last) begin
      if (k >= h) expect_level(window_total, (k + 1 < 2 * h + 1) ? k + 1 : 2 * h + 1, 1'b0);
      if (seen_count != CNT_SAT) seen_count = seen_count + 1'b1;
      ring_pos = ring_pos + 1'b1;
    end else begin
      // Flush: shrink the window from the left, one index per step.
      d = (k < h) ? k : h;
      do begin
        lim = d + h;
        expect_level(window_total, ((k < lim) ? k : lim) + 1, d == 0);
        if (d > 0 && k >= d + h) window_total = window_total - SUM_W'(square_back(d + h));
        d--;
      end while (d >= 0);
      window_total = '0;
      seen_count = '0;
      ring_pos = '0;
    end
  endfunction

  // Driver: present the next queued sample once the current one is taken,
  // or idle at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = sample_queue.pop_front();
        in_valid_i <= 1'b1;
        sample_i <= next_sample.sample;
        last_sample_i <= next_sample.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall at random; on request, hold off for a long stretch so the
  // block backs up into its sample input.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predict on every taken sample, then check every taken result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_envelope(sample_i, last_sample_i);
        samples_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_levels.size() == 0) begin
          $error("unexpected result: rms_level %0d last_result %0b", rms_level_o,
                 last_result_o);
          fail_count++;
        end else begin
          oldest_level = pending_levels.pop_front();
          if (rms_level_o !== oldest_level.level) begin
            $error("rms_level: expected %0d, got %0d", oldest_level.level, rms_level_o);
            fail_count++;
          end
          if (last_result_o !== oldest_level.last) begin
            $error("last_result: expected %0b, got %0b", oldest_level.last, last_result_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_sample(int s, bit last);
    sample_item_t it;
    it.sample = SAMPLE_W'(s);
    it.last = last;
    sample_queue.push_back(it);
    samples_queued++;
  endtask

  // Wait until every queued sample is taken and every value has come out,
  // then let the block settle.
  task automatic drain();
    while (samples_taken != samples_queued || pending_levels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the half window register; only called with the block idle.
  task automatic write_half(int v);
    drain();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    half_window_i <= HALF_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    half_cfg = HALF_W'(v);
  endtask

  // Mostly full-range samples, with the extremes, zero and small values mixed in.
  function automatic int rand_sample();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(200) - 100;
      3: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // One random phase: set the register and the idling, then queue samples.
  // Leave the signal open at the end when asked, so the next phase changes
  // the register in the middle of a signal.
  task automatic run_phase(int h, int send_pct, int stall_v, int n, int last_pct,
                           bit leave_open, bit hold);
    bit last;
    write_half(h);
    send_idle_pct = send_pct;
    stall_pct = stall_v;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) last = !leave_open;
      else last = ($urandom_range(99) < last_pct);
      add_sample(rand_sample(), last);
    end
    if (hold) hold_req = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    half_window_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    last_sample_i = 1'b0;
    out_ready_i = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    samples_queued = 0;
    samples_taken = 0;
    fail_count = 0;
    cycle_count = 0;
    window_total = '0;
    seen_count = '0;
    ring_pos = '0;
    half_cfg = HALF_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset half window, field extremes, then a short flush.
    add_sample(0, 0);
    add_sample(32767, 0);
    add_sample(-32768, 0);
    add_sample(-1, 0);
    add_sample(1, 0);
    add_sample(-32768, 1);
    // Signal of a single sample.
    add_sample(123, 1);

    // Zero half window: each value is the magnitude of its own sample.
    write_half(0);
    add_sample(-32768, 0);
    add_sample(5, 0);
    add_sample(-7, 1);

    // Widest window on a short signal, then a lone last sample.
    write_half(31);
    add_sample(32767, 0);
    add_sample(32767, 0);
    add_sample(32767, 0);
    add_sample(-32768, 1);
    add_sample(0, 1);

    // Widen the window in the middle of a signal; the running sum wraps and
    // the level saturates.
    write_half(1);
    for (int i = 0; i < 8; i++) add_sample((i % 2) ? -32768 : 32767, 0);
    write_half(3);
    add_sample(-32768, 0);
    add_sample(1, 0);
    add_sample(2, 1);

    // Random: a long signal that saturates the counters and flushes the most
    // values, then phases through every idling mode.
    run_phase(31, 0, 0, 130, 0, 0, 0);
    run_phase(0, 86, 0, 20, 10, 0, 0);
    run_phase(5, 0, 86, 20, 10, 1, 0);
    run_phase(1, 9, 9, 20, 10, 0, 0);
    run_phase(3, 0, 0, 20, 10, 0, 1);
    run_phase($urandom_range(31), 0, 0, 20, 8, 1, 0);
    run_phase($urandom_range(31), 86, 0, 20, 8, 0, 0);
    run_phase(31, 0, 86, 20, 5, 1, 0);
    run_phase($urandom_range(31), 9, 9, 20, 8, 0, 0);
    run_phase(HALF_RESET, 0, 0, 20, 10, 0, 0);

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
